@@ rtl/byte_pattern_replacer_defines.svh @@
// assertion macros for the byte pattern replacer
// no dependencies; included by the top level
`ifndef BYTE_PATTERN_REPLACER_DEFINES_SVH
`define BYTE_PATTERN_REPLACER_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define BPR_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("bpr assertion failed");
// next-cycle implication
`define BPR_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("bpr assertion failed");
`else
`define BPR_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define BPR_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

@@ rtl/bpr_pkg.sv @@
// shared constants and types of the byte pattern replacer
// no dependencies
package bpr_pkg;
	localparam int OLD_MAX   = 8;
	localparam int NEW_MAX   = 8;
	localparam int OUT_MAX   = 1024 * 2;
	localparam int PAT_BYTES = 8;
	localparam int PAT_W     = 8 * PAT_BYTES;
	localparam int LEN_W     = 4;
	localparam int CELLS     = (OLD_MAX < PAT_BYTES) ? OLD_MAX : PAT_BYTES;
	localparam int NEW_LIM   = (NEW_MAX < PAT_BYTES) ? NEW_MAX : PAT_BYTES;
	localparam int FILL_W    = (CELLS > 1) ? $clog2(CELLS) : 1;
	localparam int SER_W     = $clog2(PAT_BYTES);
	localparam int CNT_W     = $clog2(OUT_MAX + 1);
	localparam int IDX_W     = 8;
	localparam int QDEPTH    = 4;
	localparam int QPTR_W    = $clog2(QDEPTH);
	localparam int QLVL_W    = $clog2(QDEPTH + 1);

	// register indexes
	localparam logic [IDX_W-1:0] REG_OLD_LENGTH = IDX_W'(0);
	localparam logic [IDX_W-1:0] REG_OLD_BYTES  = IDX_W'(1);
	localparam logic [IDX_W-1:0] REG_NEW_LENGTH = IDX_W'(2);
	localparam logic [IDX_W-1:0] REG_NEW_BYTES  = IDX_W'(3);

	// register reset values
	localparam logic [LEN_W-1:0] RST_OLD_LENGTH = LEN_W'(2);
	localparam logic [PAT_W-1:0] RST_OLD_BYTES  = PAT_W'(688);
	localparam logic [LEN_W-1:0] RST_NEW_LENGTH = LEN_W'(1);
	localparam logic [PAT_W-1:0] RST_NEW_BYTES  = PAT_W'(126);

	// one step's worth of output: bytes 0..cnt-1 of src
	typedef struct packed {
		logic [PAT_W-1:0] src;
		logic [LEN_W-1:0] cnt;
		logic             last;
		logic             ovf;
	} rec_t;

	typedef struct packed {
		logic              at_start;
		logic [FILL_W-1:0] fill;
		logic [CELLS-1:0]  cand;
		logic [LEN_W-1:0]  act_old_len;
		logic [CNT_W-1:0]  out_count;
	} step_status_t;
endpackage

@@ rtl/bpr_if.sv @@
// channel interfaces of the byte pattern replacer
// depends on bpr_pkg for widths
interface bpr_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_in;
	logic       last_in;
	modport source (output valid, data_in, last_in, input ready);
	modport sink (input valid, data_in, last_in, output ready);
endinterface

interface bpr_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_out;
	logic       byte_valid;
	logic       last_out;
	logic       overflow;
	modport source (output valid, data_out, byte_valid, last_out, overflow, input ready);
	modport sink (input valid, data_out, byte_valid, last_out, overflow, output ready);
endinterface

interface bpr_cfg_if;
	logic                       valid;
	logic                       ready;
	logic [bpr_pkg::IDX_W-1:0] index;
	logic [bpr_pkg::PAT_W-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/byte_pattern_replacer.sv @@
// byte pattern replacer top level: configuration registers, step row, output serializer
// depends on bpr_pkg, bpr_if, bpr_step, bpr_emit and byte_pattern_replacer_defines.svh
//
// usage:
// - in_byte carries one frame byte per transfer, last_in on the final byte of the frame
// - out_byte carries one result per transfer: a byte, or an end marker (byte_valid 0,
//   data_out 0, last_out 1) when the final step leaves nothing to send
// - cfg writes old_length, old_bytes, new_length, new_bytes by index 0..3; cfg is always
//   ready, other indexes are ignored; writes take effect at the next frame's first byte
// - a taken byte's first result passes through the record queue, then the output register;
//   further results follow one per cycle while out_byte.ready is high, so a replacement of
//   n bytes yields n results
// - sustained rate is one byte per cycle while each byte yields at most one result and the
//   receiver is ready; the single output register and four-record queue ahead set the pace
// - bytes that may start a match are held back until resolved (at most seven)
// - a stalled receiver fills the record queue, then in_byte.ready drops; nothing is lost
// - reset restores the register defaults (b0 02 -> 7e) and waits for a frame start
`include "byte_pattern_replacer_defines.svh"
module byte_pattern_replacer (
	input logic        clk,
	input logic        arst_n,
	bpr_in_if.sink     in_byte,
	bpr_cfg_if.sink    cfg,
	bpr_out_if.source  out_byte
);
	import bpr_pkg::*;

	logic [LEN_W-1:0] old_length_q;
	logic [PAT_W-1:0] old_bytes_q;
	logic [LEN_W-1:0] new_length_q;
	logic [PAT_W-1:0] new_bytes_q;

	logic         take;
	logic         push;
	logic         room;
	rec_t         rec;
	step_status_t st;

	// configuration register file, written whenever a transfer lands
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			old_length_q <= RST_OLD_LENGTH;
			old_bytes_q  <= RST_OLD_BYTES;
			new_length_q <= RST_NEW_LENGTH;
			new_bytes_q  <= RST_NEW_BYTES;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_OLD_LENGTH: begin
					old_length_q <= cfg.data[LEN_W-1:0];
				end
				REG_OLD_BYTES: begin
					old_bytes_q <= cfg.data;
				end
				REG_NEW_LENGTH: begin
					new_length_q <= cfg.data[LEN_W-1:0];
				end
				REG_NEW_BYTES: begin
					new_bytes_q <= cfg.data;
				end
				default: begin
				end
			endcase
		end
	end

	// input side only waits on queue space
	assign in_byte.ready = room;
	assign take          = in_byte.valid && room;

	// row of match cells plus window and budget bookkeeping
	bpr_step u_step (
		.clk        (clk),
		.arst_n     (arst_n),
		.take       (take),
		.data_in    (in_byte.data_in),
		.last_in    (in_byte.last_in),
		.old_length (old_length_q),
		.old_bytes  (old_bytes_q),
		.new_length (new_length_q),
		.new_bytes  (new_bytes_q),
		.push       (push),
		.rec        (rec),
		.status     (st)
	);

	// records to single results, behind the output register
	bpr_emit u_emit (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.rec      (rec),
		.room     (room),
		.out_byte (out_byte)
	);

	// held bytes are always a pattern prefix, tracked by the cell at the fill length
	`BPR_ASSERT_IMP(a_window_prefix, clk, arst_n, !st.at_start && st.fill != '0, st.cand[st.fill - 1'b1])
	// held bytes never reach a whole pattern
	`BPR_ASSERT_IMP(a_window_short, clk, arst_n, !st.at_start && st.act_old_len != '0, st.fill < st.act_old_len)
	// frame start leaves no trace of the previous frame
	`BPR_ASSERT_IMP(a_start_clean, clk, arst_n, st.at_start, st.fill == '0 && st.out_count == '0 && st.cand == '0)
	// a final byte transfer always rearms the frame start
	`BPR_ASSERT_NXT(a_frame_end, clk, arst_n, take && in_byte.last_in, st.at_start)
	// an end marker closes the frame with a zero byte
	`BPR_ASSERT_IMP(a_marker, clk, arst_n, out_byte.valid && !out_byte.byte_valid, out_byte.last_out && out_byte.data_out == 8'h00)
endmodule

@@ rtl/bpr_cell.sv @@
// one match cell: tracks whether the window suffix of its length is a pattern prefix
// no dependencies
module bpr_cell (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic       clear,
	input  logic       keep,
	input  logic       left_cand,
	input  logic [7:0] byte_in,
	input  logic [7:0] pat_byte,
	output logic       cand,
	output logic       hit
);
	logic cand_q;

	// suffix one shorter matched, and the new byte extends it
	assign hit = left_cand & (byte_in == pat_byte);
	assign cand = cand_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cand_q <= 1'b0;
		end else if (step) begin
			cand_q <= hit & keep & ~clear;
		end
	end
endmodule

@@ rtl/bpr_step.sv @@
// per-byte step: row of match cells, window fill, frame state, output budget
// depends on bpr_pkg and bpr_cell
module bpr_step (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         take,
	input  logic [7:0]                   data_in,
	input  logic                         last_in,
	input  logic [bpr_pkg::LEN_W-1:0]    old_length,
	input  logic [bpr_pkg::PAT_W-1:0]    old_bytes,
	input  logic [bpr_pkg::LEN_W-1:0]    new_length,
	input  logic [bpr_pkg::PAT_W-1:0]    new_bytes,
	output logic                         push,
	output bpr_pkg::rec_t                rec,
	output bpr_pkg::step_status_t        status
);
	import bpr_pkg::*;

	logic              start_q;
	logic [FILL_W-1:0] fill_q;
	logic [CNT_W-1:0]  count_q;
	logic              ovf_q;
	logic [LEN_W-1:0]  act_old_len_q;
	logic [PAT_W-1:0]  act_old_pat_q;
	logic [LEN_W-1:0]  act_new_len_q;
	logic [PAT_W-1:0]  act_new_pat_q;

	logic [CELLS-1:0]  cand;
	logic [CELLS-1:0]  hit;
	logic [CELLS-1:0]  keep;
	logic              clear;
	logic              full;
	logic [FILL_W-1:0] f_new;
	logic [FILL_W-1:0] fill_d;
	logic [LEN_W-1:0]  fill_inc;
	logic [LEN_W-1:0]  cnt_raw;
	logic [LEN_W-1:0]  emitted;
	logic [PAT_W-1:0]  src;
	logic [PAT_W-1:0]  prefix_src;
	logic [CNT_W-1:0]  remaining;
	logic              drop;
	logic              ovf_now;
	logic [LEN_W-1:0]  old_clamp;
	logic [LEN_W-1:0]  new_clamp;

	assign old_clamp = (old_length > LEN_W'(CELLS)) ? LEN_W'(CELLS) : old_length;
	assign new_clamp = (new_length > LEN_W'(NEW_LIM)) ? LEN_W'(NEW_LIM) : new_length;

	for (genvar k = 0; k < CELLS; k++) begin : g_cell
		logic left;
		if (k == 0) begin : g_first
			assign left = 1'b1;
		end else begin : g_rest
			assign left = cand[k-1];
		end
		assign keep[k] = (LEN_W'(k + 1) < act_old_len_q);
		bpr_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.step      (take),
			.clear     (clear),
			.keep      (keep[k]),
			.left_cand (left),
			.byte_in   (data_in),
			.pat_byte  (act_old_pat_q[8*k +: 8]),
			.cand      (cand[k]),
			.hit       (hit[k])
		);
	end

	always_comb begin
		f_new = '0;
		for (int k = 0; k < CELLS; k++) begin
			if (hit[k] && keep[k]) begin
				f_new = FILL_W'(k + 1);
			end
		end
		for (int i = 0; i < PAT_BYTES; i++) begin
			prefix_src[8*i +: 8] = (LEN_W'(i) < LEN_W'(fill_q)) ?
				act_old_pat_q[8*i +: 8] : data_in;
		end
	end

	assign fill_inc = LEN_W'(fill_q) + LEN_W'(1);
	// whole pattern seen; a one-byte pattern on the final byte stays
	assign full = (act_old_len_q != '0) &&
		hit[FILL_W'(act_old_len_q - LEN_W'(1))] &&
		!(last_in && (act_old_len_q == LEN_W'(1)));

	always_comb begin
		if (start_q || (act_old_len_q == '0)) begin
			src     = {{(PAT_W-8){1'b0}}, data_in};
			cnt_raw = LEN_W'(1);
			clear   = 1'b1;
			fill_d  = '0;
		end else if (full) begin
			src     = act_new_pat_q;
			cnt_raw = act_new_len_q;
			clear   = 1'b1;
			fill_d  = '0;
		end else begin
			src     = prefix_src;
			cnt_raw = last_in ? fill_inc : fill_inc - LEN_W'(f_new);
			clear   = last_in;
			fill_d  = f_new;
		end
	end

	// output budget of the frame
	assign remaining = CNT_W'(OUT_MAX) - count_q;
	assign drop      = CNT_W'(cnt_raw) > remaining;
	assign emitted   = drop ? LEN_W'(remaining) : cnt_raw;
	assign ovf_now   = ovf_q | drop;

	assign push     = take && ((emitted != '0) || last_in);
	assign rec.src  = src;
	assign rec.cnt  = emitted;
	assign rec.last = last_in;
	assign rec.ovf  = ovf_now;

	assign status.at_start    = start_q;
	assign status.fill        = fill_q;
	assign status.cand        = cand;
	assign status.act_old_len = act_old_len_q;
	assign status.out_count   = count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= 1'b1;
			fill_q  <= '0;
			count_q <= '0;
			ovf_q   <= 1'b0;
		end else if (take) begin
			start_q <= last_in;
			if (last_in) begin
				fill_q  <= '0;
				count_q <= '0;
				ovf_q   <= 1'b0;
			end else begin
				fill_q  <= fill_d;
				count_q <= count_q + CNT_W'(emitted);
				ovf_q   <= ovf_now;
			end
		end
	end

	// pattern copy taken at the first byte of each frame
	always_ff @(posedge clk) begin
		if (take && start_q) begin
			act_old_len_q <= old_clamp;
			act_old_pat_q <= old_bytes;
			act_new_len_q <= new_clamp;
			act_new_pat_q <= new_bytes;
		end
	end
endmodule

@@ rtl/bpr_emit.sv @@
// step record queue and serializer feeding the output register
// depends on bpr_pkg and bpr_if
module bpr_emit (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  bpr_pkg::rec_t    rec,
	output logic             room,
	bpr_out_if.source        out_byte
);
	import bpr_pkg::*;

	rec_t              queue_q [QDEPTH];
	logic [QPTR_W-1:0] wr_q;
	logic [QPTR_W-1:0] rd_q;
	logic [QLVL_W-1:0] level_q;
	logic [SER_W-1:0]  idx_q;
	logic              ovalid_q;
	logic [7:0]        data_q;
	logic              bvalid_q;
	logic              last_q;
	logic              ovf_q;

	rec_t head;
	logic nonempty;
	logic advance;
	logic load;
	logic at_end;
	logic pop;

	assign head     = queue_q[rd_q];
	assign nonempty = (level_q != '0);
	assign room     = (level_q != QLVL_W'(QDEPTH));
	assign advance  = !ovalid_q || out_byte.ready;
	assign load     = advance && nonempty;
	assign at_end   = (head.cnt == '0) || (idx_q == SER_W'(head.cnt - LEN_W'(1)));
	assign pop      = load && at_end;

	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_q] <= rec;
		end
		if (load) begin
			data_q   <= (head.cnt == '0) ? 8'h00 : head.src[8*idx_q +: 8];
			bvalid_q <= (head.cnt != '0);
			last_q   <= head.last && at_end;
			ovf_q    <= head.ovf;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q     <= '0;
			rd_q     <= '0;
			level_q  <= '0;
			idx_q    <= '0;
			ovalid_q <= 1'b0;
		end else begin
			if (push) begin
				wr_q <= wr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_q <= rd_q + QPTR_W'(1);
			end
			level_q <= level_q + QLVL_W'(push) - QLVL_W'(pop);
			if (load) begin
				idx_q <= at_end ? '0 : idx_q + SER_W'(1);
			end
			if (advance) begin
				ovalid_q <= nonempty;
			end
		end
	end

	assign out_byte.valid      = ovalid_q;
	assign out_byte.data_out   = data_q;
	assign out_byte.byte_valid = bvalid_q;
	assign out_byte.last_out   = last_q;
	assign out_byte.overflow   = ovf_q;
endmodule
